// File: design/mcfsp_pkg.sv
// Shared types, constants and command codes for the min-cost flow unit.
// Used by mcfsp_ctrl, mcfsp_dp and min_cost_flow_successive_paths_unit.
`default_nettype none
package mcfsp_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = NODE_W + 1;
	localparam int ADDR_W    = 2 * NODE_W;
	localparam int DEPTH     = MAX_NODES * MAX_NODES;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// request kinds (s_tuser)
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_RUN   = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// result kinds (m_tuser)
	localparam logic RES_RUN  = 1'b0;
	localparam logic RES_READ = 1'b1;

	// config register indexes
	localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
	localparam logic [1:0] CFG_SOURCE     = 2'd1;
	localparam logic [1:0] CFG_SINK       = 2'd2;
	localparam logic [1:0] CFG_FLOW_LIMIT = 2'd3;

	// datapath operations
	typedef logic [4:0] op_t;
	localparam op_t OP_NOP        = 5'd0;
	localparam op_t OP_CLEAR      = 5'd1;
	localparam op_t OP_LOAD       = 5'd2;
	localparam op_t OP_WR_AB      = 5'd3;
	localparam op_t OP_WR_BA      = 5'd4;
	localparam op_t OP_RD_ISSUE   = 5'd5;
	localparam op_t OP_RD_DONE    = 5'd6;
	localparam op_t OP_EMIT       = 5'd7;
	localparam op_t OP_RUN_INIT   = 5'd8;
	localparam op_t OP_INIT_BEGIN = 5'd9;
	localparam op_t OP_INIT       = 5'd10;
	localparam op_t OP_SRC        = 5'd11;
	localparam op_t OP_SW_RD      = 5'd12;
	localparam op_t OP_NEXT_I     = 5'd13;
	localparam op_t OP_OPEN       = 5'd14;
	localparam op_t OP_RX_RD      = 5'd15;
	localparam op_t OP_RX_EV      = 5'd16;
	localparam op_t OP_SWEEP_END  = 5'd17;
	localparam op_t OP_DT_RD      = 5'd18;
	localparam op_t OP_WALK_INIT  = 5'd19;
	localparam op_t OP_WK_RD      = 5'd20;
	localparam op_t OP_WK_STEP    = 5'd21;
	localparam op_t OP_AUG_INIT   = 5'd22;
	localparam op_t OP_AG_PRD     = 5'd23;
	localparam op_t OP_AG_FRD     = 5'd24;
	localparam op_t OP_AG_FWR     = 5'd25;
	localparam op_t OP_AG_RRD     = 5'd26;
	localparam op_t OP_AG_RWR     = 5'd27;
	localparam op_t OP_ACCUM      = 5'd28;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
		logic ends_ok;
		logic paths_lt;
		logic i_last;
		logic j_last;
		logic skip;
		logic improved;
		logic sweep_last;
		logic t_inf;
		logic cur_is_s;
		logic steps_done;
	} status_t;

endpackage
`default_nettype wire

// File: design/mcfsp_ctrl.sv
// Sequencer for the min-cost flow unit: one state per datapath step.
// Depends on mcfsp_pkg; drives mcfsp_dp through cmd_t, reads status_t.
`default_nettype none
module mcfsp_ctrl import mcfsp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [1:0] req,
	input  wire status_t    st,
	output cmd_t            cmd,
	output logic            in_ready
);

	localparam logic [4:0] S_CLEAR    = 5'd0;
	localparam logic [4:0] S_IDLE     = 5'd1;
	localparam logic [4:0] S_WR_AB    = 5'd2;
	localparam logic [4:0] S_WR_BA    = 5'd3;
	localparam logic [4:0] S_RD_ISSUE = 5'd4;
	localparam logic [4:0] S_RD_DONE  = 5'd5;
	localparam logic [4:0] S_EMIT     = 5'd6;
	localparam logic [4:0] S_RUN      = 5'd7;
	localparam logic [4:0] S_PCHK     = 5'd8;
	localparam logic [4:0] S_INIT     = 5'd9;
	localparam logic [4:0] S_SRC      = 5'd10;
	localparam logic [4:0] S_SW_RD    = 5'd11;
	localparam logic [4:0] S_SW_CHK   = 5'd12;
	localparam logic [4:0] S_RX_RD    = 5'd13;
	localparam logic [4:0] S_RX_EV    = 5'd14;
	localparam logic [4:0] S_SW_END   = 5'd15;
	localparam logic [4:0] S_DT_RD    = 5'd16;
	localparam logic [4:0] S_DT_CHK   = 5'd17;
	localparam logic [4:0] S_WK_TEST  = 5'd18;
	localparam logic [4:0] S_WK_STEP  = 5'd19;
	localparam logic [4:0] S_AUG_INIT = 5'd20;
	localparam logic [4:0] S_AG_TEST  = 5'd21;
	localparam logic [4:0] S_AG_FRD   = 5'd22;
	localparam logic [4:0] S_AG_FWR   = 5'd23;
	localparam logic [4:0] S_AG_RRD   = 5'd24;
	localparam logic [4:0] S_AG_RWR   = 5'd25;
	localparam logic [4:0] S_ACCUM    = 5'd26;

	logic [4:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NOP;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					cmd.op = OP_LOAD;
					unique case (req)
						REQ_WRITE: state_d = S_WR_AB;
						REQ_RUN:   state_d = S_RUN;
						REQ_READ:  state_d = S_RD_ISSUE;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_WR_AB: begin
				cmd.op  = OP_WR_AB;
				state_d = S_WR_BA;
			end
			S_WR_BA: begin
				cmd.op  = OP_WR_BA;
				state_d = S_IDLE;
			end
			S_RD_ISSUE: begin
				cmd.op  = OP_RD_ISSUE;
				state_d = S_RD_DONE;
			end
			S_RD_DONE: begin
				cmd.op  = OP_RD_DONE;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			S_RUN: begin
				cmd.op  = OP_RUN_INIT;
				state_d = st.ends_ok ? S_PCHK : S_EMIT;
			end
			S_PCHK: begin
				if (st.paths_lt) begin
					cmd.op  = OP_INIT_BEGIN;
					state_d = S_INIT;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_INIT: begin
				cmd.op = OP_INIT;
				if (st.i_last) state_d = S_SRC;
			end
			S_SRC: begin
				cmd.op  = OP_SRC;
				state_d = S_SW_RD;
			end
			S_SW_RD: begin
				cmd.op  = OP_SW_RD;
				state_d = S_SW_CHK;
			end
			S_SW_CHK: begin
				if (st.skip) begin
					cmd.op  = OP_NEXT_I;
					state_d = st.i_last ? S_SW_END : S_SW_RD;
				end else begin
					cmd.op  = OP_OPEN;
					state_d = S_RX_RD;
				end
			end
			S_RX_RD: begin
				cmd.op  = OP_RX_RD;
				state_d = S_RX_EV;
			end
			S_RX_EV: begin
				cmd.op = OP_RX_EV;
				if (!st.j_last)     state_d = S_RX_RD;
				else if (st.i_last) state_d = S_SW_END;
				else                state_d = S_SW_RD;
			end
			S_SW_END: begin
				cmd.op = OP_SWEEP_END;
				if (!st.improved)       state_d = S_DT_RD;
				else if (st.sweep_last) state_d = S_EMIT;
				else                    state_d = S_SW_RD;
			end
			S_DT_RD: begin
				cmd.op  = OP_DT_RD;
				state_d = S_DT_CHK;
			end
			S_DT_CHK: begin
				if (st.t_inf) begin
					state_d = S_EMIT;
				end else begin
					cmd.op  = OP_WALK_INIT;
					state_d = S_WK_TEST;
				end
			end
			S_WK_TEST: begin
				if (st.cur_is_s) begin
					state_d = S_AUG_INIT;
				end else if (st.steps_done) begin
					state_d = S_EMIT;
				end else begin
					cmd.op  = OP_WK_RD;
					state_d = S_WK_STEP;
				end
			end
			S_WK_STEP: begin
				cmd.op  = OP_WK_STEP;
				state_d = S_WK_TEST;
			end
			S_AUG_INIT: begin
				cmd.op  = OP_AUG_INIT;
				state_d = S_AG_TEST;
			end
			S_AG_TEST: begin
				if (st.cur_is_s) begin
					state_d = S_ACCUM;
				end else begin
					cmd.op  = OP_AG_PRD;
					state_d = S_AG_FRD;
				end
			end
			S_AG_FRD: begin
				cmd.op  = OP_AG_FRD;
				state_d = S_AG_FWR;
			end
			S_AG_FWR: begin
				cmd.op  = OP_AG_FWR;
				state_d = S_AG_RRD;
			end
			S_AG_RRD: begin
				cmd.op  = OP_AG_RRD;
				state_d = S_AG_RWR;
			end
			S_AG_RWR: begin
				cmd.op  = OP_AG_RWR;
				state_d = S_AG_TEST;
			end
			S_ACCUM: begin
				cmd.op  = OP_ACCUM;
				state_d = S_PCHK;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

// File: design/mcfsp_dp.sv
// Datapath: config registers, capacity/cost/distance/parent memories,
// loop counters, relaxation adder and result register. Depends on mcfsp_pkg.
`default_nettype none
module mcfsp_dp import mcfsp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output status_t          st,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic [79:0] in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             out_kind,
	output logic [55:0]      out_data
);

	// config
	logic [6:0] node_count_q;
	logic [5:0] source_q, sink_q;
	logic [7:0] flow_limit_q;

	// latched request
	logic [5:0]         a_q, b_q;
	logic [15:0]        capf_q, costf_q, capb_q, costb_q;

	// memories; a distance entry carries the node's settled flag in bit 32
	logic [15:0]        cap_mem  [DEPTH];
	logic [15:0]        cost_mem [DEPTH];
	logic [32:0]        dist_mem [MAX_NODES];
	logic [NODE_W-1:0]  par_mem  [MAX_NODES];
	logic [15:0]        cap_rd_q, cost_rd_q;
	logic [32:0]        dist_rd_q;
	logic [NODE_W-1:0]  par_rd_q;

	// control/loop state
	logic [ADDR_W-1:0]  clr_addr_q;
	logic [CNT_W-1:0]   n_q, sweep_q, steps_q;
	logic [NODE_W-1:0]  i_q, j_q, cur_q, v_q;
	logic signed [31:0] di_q, dt_q, total_q;
	logic [7:0]         paths_q;
	logic               improved_q;
	logic               res_kind_q;
	logic [15:0]        res_cap_q;
	logic               out_valid_q;

	logic [NODE_W-1:0]  src_idx, snk_idx, a_idx, b_idx;
	logic [CNT_W-1:0]   n_eff;

	// memory port controls
	logic               cap_we, cap_re, cost_we, cost_re, dist_we, dist_re, par_we, par_re;
	logic [ADDR_W-1:0]  cap_wa, cap_ra, cost_wa;
	logic [15:0]        cap_wd, cost_wd;
	logic [NODE_W-1:0]  dist_wa, dist_ra, par_ra;
	logic [32:0]        dist_wd;

	// relaxation
	logic signed [32:0] cand_full;
	logic signed [31:0] cand;
	logic               relax;
	logic signed [32:0] tsum;
	logic signed [31:0] tsat;

	assign src_idx = NODE_W'(source_q);
	assign snk_idx = NODE_W'(sink_q);
	assign a_idx   = NODE_W'(a_q);
	assign b_idx   = NODE_W'(b_q);
	assign n_eff   = (CNT_W'(node_count_q) > CNT_W'(MAX_NODES)) ?
		CNT_W'(MAX_NODES) : CNT_W'(node_count_q);

	assign cand_full = {di_q[31], di_q} + 33'(signed'(cost_rd_q));
	assign cand = (cand_full[32:31] == 2'b10) ? S32_MIN : cand_full[31:0];
	// upper overflow can never beat a stored distance
	assign relax = (cap_rd_q != 16'd0) && (cand_full[32:31] != 2'b01)
		&& ($signed(dist_rd_q[31:0]) > cand);

	assign tsum = {total_q[31], total_q} + {dt_q[31], dt_q};
	always_comb begin
		case (tsum[32:31])
			2'b01:   tsat = S32_MAX;
			2'b10:   tsat = S32_MIN;
			default: tsat = tsum[31:0];
		endcase
	end

	// status
	always_comb begin
		st.clr_last   = (clr_addr_q == ADDR_W'(DEPTH - 1));
		st.out_free   = !out_valid_q || out_ready;
		st.ends_ok    = ({1'b0, source_q} < 7'(n_eff)) && ({1'b0, sink_q} < 7'(n_eff));
		st.paths_lt   = (paths_q < flow_limit_q);
		st.i_last     = ({1'b0, i_q} == n_q - CNT_W'(1));
		st.j_last     = ({1'b0, j_q} == n_q - CNT_W'(1));
		st.skip       = ($signed(dist_rd_q[31:0]) == S32_MAX) || dist_rd_q[32];
		st.improved   = improved_q;
		st.sweep_last = (sweep_q == n_q);
		st.t_inf      = ($signed(dist_rd_q[31:0]) == S32_MAX);
		st.cur_is_s   = (cur_q == src_idx);
		st.steps_done = (steps_q == n_q);
	end

	// memory port selection
	always_comb begin
		cap_we  = 1'b0; cap_wa  = clr_addr_q; cap_wd = 16'd0;
		cap_re  = 1'b0; cap_ra  = {i_q, j_q};
		cost_we = 1'b0; cost_wa = clr_addr_q; cost_wd = 16'd0;
		cost_re = 1'b0;
		dist_we = 1'b0; dist_wa = i_q; dist_wd = {1'b0, S32_MAX};
		dist_re = 1'b0; dist_ra = i_q;
		par_we  = 1'b0; par_re  = 1'b0; par_ra = cur_q;
		case (cmd.op)
			OP_CLEAR: begin
				cap_we  = 1'b1;
				cost_we = 1'b1;
			end
			OP_WR_AB: begin
				cap_we = 1'b1;  cap_wa = {a_idx, b_idx};  cap_wd = capf_q;
				cost_we = 1'b1; cost_wa = {a_idx, b_idx}; cost_wd = costf_q;
			end
			OP_WR_BA: begin
				cap_we = 1'b1;  cap_wa = {b_idx, a_idx};  cap_wd = capb_q;
				cost_we = 1'b1; cost_wa = {b_idx, a_idx}; cost_wd = costb_q;
			end
			OP_RD_ISSUE: begin
				cap_re = 1'b1;
				cap_ra = {a_idx, b_idx};
			end
			OP_INIT: dist_we = 1'b1;
			OP_SRC: begin
				dist_we = 1'b1;
				dist_wa = src_idx;
				dist_wd = 33'd0;
			end
			OP_SW_RD: dist_re = 1'b1;
			// mark node i settled, distance unchanged
			OP_OPEN: begin
				dist_we = 1'b1;
				dist_wd = {1'b1, dist_rd_q[31:0]};
			end
			OP_RX_RD: begin
				cap_re  = 1'b1;
				cost_re = 1'b1;
				dist_re = 1'b1;
				dist_ra = j_q;
			end
			OP_RX_EV: begin
				dist_we = relax;
				dist_wa = j_q;
				dist_wd = {1'b0, cand};
				par_we  = relax;
			end
			OP_DT_RD: begin
				dist_re = 1'b1;
				dist_ra = snk_idx;
			end
			OP_WK_RD, OP_AG_PRD: par_re = 1'b1;
			OP_AG_FRD: begin
				cap_re = 1'b1;
				cap_ra = {par_rd_q, cur_q};
			end
			OP_AG_FWR: begin
				cap_we = 1'b1;
				cap_wa = {v_q, cur_q};
				cap_wd = cap_rd_q - 16'((cap_rd_q != 16'd0));
			end
			OP_AG_RRD: begin
				cap_re = 1'b1;
				cap_ra = {cur_q, v_q};
			end
			OP_AG_RWR: begin
				cap_we = 1'b1;
				cap_wa = {cur_q, v_q};
				cap_wd = cap_rd_q + 16'((cap_rd_q != 16'hFFFF));
			end
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (cap_we)  cap_mem[cap_wa]   <= cap_wd;
		if (cap_re)  cap_rd_q          <= cap_mem[cap_ra];
		if (cost_we) cost_mem[cost_wa] <= cost_wd;
		if (cost_re) cost_rd_q         <= cost_mem[cap_ra];
		if (dist_we) dist_mem[dist_wa] <= dist_wd;
		if (dist_re) dist_rd_q         <= dist_mem[dist_ra];
		if (par_we)  par_mem[j_q]      <= i_q;
		if (par_re)  par_rd_q          <= par_mem[par_ra];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 7'd64;
			source_q     <= 6'd0;
			sink_q       <= 6'd63;
			flow_limit_q <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE_COUNT: node_count_q <= cfg_data[6:0];
				CFG_SOURCE:     source_q     <= cfg_data[5:0];
				CFG_SINK:       sink_q       <= cfg_data[5:0];
				CFG_FLOW_LIMIT: flow_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_CLEAR) clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (cmd.op == OP_EMIT)  out_valid_q <= 1'b1;
			else if (out_ready)     out_valid_q <= 1'b0;
		end
	end

	// payload and loop registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				a_q     <= in_data[5:0];
				b_q     <= in_data[11:6];
				capf_q  <= in_data[27:12];
				costf_q <= in_data[43:28];
				capb_q  <= in_data[59:44];
				costb_q <= in_data[75:60];
			end
			OP_RD_DONE: begin
				res_kind_q <= RES_READ;
				res_cap_q  <= cap_rd_q;
				total_q    <= '0;
				paths_q    <= '0;
			end
			OP_EMIT: begin
				out_kind <= res_kind_q;
				out_data <= {res_cap_q, paths_q, total_q};
			end
			OP_RUN_INIT: begin
				res_kind_q <= RES_RUN;
				res_cap_q  <= '0;
				total_q    <= '0;
				paths_q    <= '0;
				n_q        <= n_eff;
			end
			OP_INIT_BEGIN: i_q <= '0;
			OP_INIT: i_q <= i_q + NODE_W'(1);
			OP_SRC: begin
				i_q        <= '0;
				j_q        <= '0;
				sweep_q    <= '0;
				improved_q <= 1'b0;
			end
			OP_NEXT_I: i_q <= i_q + NODE_W'(1);
			OP_OPEN: begin
				di_q <= dist_rd_q[31:0];
				j_q  <= '0;
			end
			OP_RX_EV: begin
				if (relax) begin
					improved_q <= 1'b1;
					// a self loop lowers the node's own distance mid-scan
					if (j_q == i_q) di_q <= cand;
				end
				if (st.j_last) begin
					j_q <= '0;
					i_q <= i_q + NODE_W'(1);
				end else begin
					j_q <= j_q + NODE_W'(1);
				end
			end
			OP_SWEEP_END: begin
				sweep_q    <= sweep_q + CNT_W'(1);
				improved_q <= 1'b0;
				i_q        <= '0;
			end
			OP_WALK_INIT: begin
				dt_q    <= dist_rd_q[31:0];
				cur_q   <= snk_idx;
				steps_q <= '0;
			end
			OP_WK_STEP: begin
				cur_q   <= par_rd_q;
				steps_q <= steps_q + CNT_W'(1);
			end
			OP_AUG_INIT: cur_q <= snk_idx;
			OP_AG_FRD:   v_q   <= par_rd_q;
			OP_AG_RWR:   cur_q <= v_q;
			OP_ACCUM: begin
				total_q <= tsat;
				paths_q <= paths_q + 8'd1;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: design/min_cost_flow_successive_paths_unit.sv
// Top level of the min-cost flow unit (successive shortest paths).
// Depends on mcfsp_pkg, mcfsp_ctrl and mcfsp_dp.
//
// channel | dir | handshake           | payload
// --------+-----+---------------------+--------------------------------------
// s_      | in  | s_tvalid / s_tready | s_tuser req_type, s_tdata edge fields
// m_      | out | m_tvalid / m_tready | m_tuser result_kind, m_tdata result
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// After reset the capacity and cost memories are swept to zero, one entry a
// cycle over all 4096 entries, with s_tready low (cfg writes are still taken).
// Edge write: accept, then two memory writes. Read: accept, read, capture, emit.
// Run: per path, an init pass over n nodes, then Bellman-Ford sweeps: a read
// and check of each node, and for an open node a read and relax step per j,
// then a sweep end, up to n+1 sweeps; then a parent walk from the sink checks
// each hop, and each hop is updated (parent, forward and reverse capacity).
// The result sits in an output register; s_tready returns while it waits.
`default_nettype none
module min_cost_flow_successive_paths_unit import mcfsp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // node_a, node_b, cap_forward, cost_forward,
	                                    // cap_backward, cost_backward, 4'b0 pad
	input  wire logic [1:0]  s_tuser,  // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,  // total_cost, paths_found, residual_cap
	output logic             m_tuser,  // result_kind
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	cmd_t    cmd;
	status_t st;
	logic    accept;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	mcfsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req      (s_tuser),
		.st       (st),
		.cmd      (cmd),
		.in_ready (s_tready)
	);

	mcfsp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire
